>>> rtl/b64_pkg.sv
`timescale 1ns / 1ps
// Types, constants and alphabet helpers shared by the Base64 codec.
// No dependencies; the core, the codec and the bench import this package.
package b64_pkg;

   localparam int SYM_W       = 7;
   localparam int ALPHA_SIZE  = 64;
   localparam int ALPHA_WORDS = 7;
   localparam int ALPHA_BITS  = ALPHA_WORDS * 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PAD_RESET   = 61;

   // register index of the pad symbol; indexes below it select alphabet words
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_IDX = 3'd7;

   typedef enum logic [1:0] {
      FUNC_ENCODE = 2'd0,
      FUNC_DECODE = 2'd1,
      FUNC_FINISH = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] value;
   } item_type;

   // up to four result words of one item, entry 0 goes out first
   typedef struct packed {
      logic [3:0][7:0] val;
      logic [2:0]      n;
   } res_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] idx;
   } lookup_type;

   // symbol held at alphabet index idx
   function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_BITS-1:0] alpha,
                                               input logic [5:0] idx);
      logic [8:0] pos;
      pos = {3'b000, idx} * 9'd7;
      return alpha[pos +: SYM_W];
   endfunction

   // reverse lookup; the highest matching index wins, codes of 128 and up miss
   function automatic lookup_type rlookup(input logic [ALPHA_BITS-1:0] alpha,
                                          input logic [7:0] code);
      lookup_type r;
      r = '0;
      for (int i = 0; i < ALPHA_SIZE; i++) begin
         if (!code[7] && alpha[i*SYM_W +: SYM_W] == code[6:0]) begin
            r.hit = 1'b1;
            r.idx = 6'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/b64_req_if.sv
`timescale 1ns / 1ps
// Input channel of the Base64 codec: function code and byte or symbol.
// Depends on nothing.
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] in_value;

   modport source (output valid, output func, output in_value, input ready);
   modport sink   (input valid, input func, input in_value, output ready);
endinterface

>>> rtl/b64_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the Base64 codec: one symbol or byte per word.
// Depends on nothing.
interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_value;
   logic       out_last;

   modport source (output valid, output out_value, output out_last, input ready);
   modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

>>> rtl/b64_csr_if.sv
`timescale 1ns / 1ps
// Register write channel of the Base64 codec: register index and data.
// Depends on nothing.
interface b64_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/b64_core.sv
`timescale 1ns / 1ps
// Group state and per-item step of the Base64 codec: takes one item, updates
// the partial group and forms its result words. Uses b64_pkg.
module b64_core
   import b64_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  item_type              item,
   input  logic [ALPHA_BITS-1:0] alpha,
   input  logic [SYM_W-1:0]      pad,
   output res_type               res
);

   logic [17:0] buf_ff, buf_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        stop_ff, stop_in;
   logic        dec_ff, dec_in;

   logic [17:0]     b;
   logic [1:0]      c;
   logic            s;
   logic [23:0]     t;
   lookup_type      lk;
   logic [3:0][5:0] sidx;
   logic [3:0]      use_sym;
   logic [3:0]      use_pad;

   // step one item through the group state
   always_comb begin
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      dec_in  = dec_ff;
      res     = '0;
      sidx    = '0;
      use_sym = '0;
      use_pad = '0;
      t       = '0;
      b       = buf_ff;
      c       = cnt_ff;
      s       = stop_ff;
      lk      = rlookup(alpha, item.value);

      case (func_type'(item.func))
         FUNC_ENCODE: begin
            // a change of direction drops the partial group
            if (dec_ff) begin
               b = '0;
               c = '0;
               s = 1'b0;
            end
            dec_in  = 1'b0;
            stop_in = s;
            if (c < 2'd2) begin
               buf_in = {2'b00, b[7:0], item.value};
               cnt_in = c + 2'd1;
            end else begin
               t       = {b[15:0], item.value};
               sidx[0] = t[23:18];
               sidx[1] = t[17:12];
               sidx[2] = t[11:6];
               sidx[3] = t[5:0];
               use_sym = 4'b1111;
               res.n   = 3'd4;
               buf_in  = '0;
               cnt_in  = '0;
            end
         end
         FUNC_DECODE: begin
            if (!dec_ff) begin
               b = '0;
               c = '0;
               s = 1'b0;
            end
            dec_in  = 1'b1;
            stop_in = s;
            buf_in  = b;
            cnt_in  = c;
            if (!s) begin
               if (!lk.hit) begin
                  // first invalid symbol: flush the partial group and stop
                  if (c == 2'd3) begin
                     res.val[0] = b[17:10];
                     res.val[1] = b[9:2];
                     res.n      = 3'd2;
                  end else if (c == 2'd2) begin
                     res.val[0] = b[11:4];
                     res.n      = 3'd1;
                  end
                  stop_in = 1'b1;
                  buf_in  = '0;
                  cnt_in  = '0;
               end else if (c < 2'd3) begin
                  buf_in = {b[11:0], lk.idx};
                  cnt_in = c + 2'd1;
               end else begin
                  t          = {b, lk.idx};
                  res.val[0] = t[23:16];
                  res.val[1] = t[15:8];
                  res.val[2] = t[7:0];
                  res.n      = 3'd3;
                  buf_in     = '0;
                  cnt_in     = '0;
               end
            end
         end
         FUNC_FINISH: begin
            if (dec_ff) begin
               if (cnt_ff == 2'd3) begin
                  res.val[0] = buf_ff[17:10];
                  res.val[1] = buf_ff[9:2];
                  res.n      = 3'd2;
               end else if (cnt_ff == 2'd2) begin
                  res.val[0] = buf_ff[11:4];
                  res.n      = 3'd1;
               end
            end else begin
               if (cnt_ff == 2'd1) begin
                  sidx[0] = buf_ff[7:2];
                  sidx[1] = {buf_ff[1:0], 4'b0000};
                  use_sym = 4'b0011;
                  use_pad = 4'b1100;
                  res.n   = 3'd4;
               end else if (cnt_ff == 2'd2) begin
                  sidx[0] = buf_ff[15:10];
                  sidx[1] = buf_ff[9:4];
                  sidx[2] = {buf_ff[3:0], 2'b00};
                  use_sym = 4'b0111;
                  use_pad = 4'b1000;
                  res.n   = 3'd4;
               end
            end
            buf_in  = '0;
            cnt_in  = '0;
            stop_in = 1'b0;
         end
         default: begin
         end
      endcase

      // map encode indexes to symbols, fill pads
      for (int k = 0; k < 4; k++) begin
         if (use_sym[k]) begin
            res.val[k] = {1'b0, sym_at(alpha, sidx[k])};
         end else if (use_pad[k]) begin
            res.val[k] = {1'b0, pad};
         end
      end
   end

   // hold the group state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
         dec_ff  <= 1'b0;
      end else if (take) begin
         buf_ff  <= buf_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
         dec_ff  <= dec_in;
      end
   end

endmodule

>>> rtl/base64_codec.sv
`timescale 1ns / 1ps
// Streaming Base64 encoder and decoder with a programmable 64-symbol
// alphabet (registers 0 to 6, seven bits a symbol) and pad symbol (register 7).
// An accepted word is held in the input register, is then stepped
// through the group state, and its zero to four result words go to a result
// buffer that drains one word per cycle while the receiver is ready; out_last
// marks the last word of an item. The result buffer sets the rate: the next
// word is taken into the input register while results still drain, but is
// stepped only once the buffer is empty or frees its last word.
// Write registers only while idle.
// Depends on b64_pkg, the three channel interfaces and b64_core.
module base64_codec
   import b64_pkg::*;
(
   input logic       clock,
   input logic       reset,
   b64_req_if.sink   req_chan,
   b64_rsp_if.source rsp_chan,
   b64_csr_if.sink   csr_chan
);

   logic [ALPHA_WORDS-1:0][CSR_DATA_W-1:0] alpha_ff;
   logic [SYM_W-1:0]                       pad_ff;

   logic     in_vld_ff;
   item_type in_item_ff;

   logic [3:0][7:0] grp_val_ff;
   logic [2:0]      grp_left_ff;

   logic    advance;
   logic    rsp_fire;
   res_type res;

   // registers: always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
         pad_ff   <= SYM_W'(PAD_RESET);
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_PAD_IDX) begin
            pad_ff <= csr_chan.wdata[SYM_W-1:0];
         end else begin
            alpha_ff[csr_chan.index] <= csr_chan.wdata;
         end
      end
   end

   // move an item on once the result buffer is empty or frees this cycle
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign advance  = in_vld_ff &&
                     (grp_left_ff == 3'd0 || (grp_left_ff == 3'd1 && rsp_chan.ready));
   assign req_chan.ready = !in_vld_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.func  <= req_chan.func;
         in_item_ff.value <= req_chan.in_value;
      end
   end

   b64_core u_core (
      .clock (clock),
      .reset (reset),
      .take  (advance),
      .item  (in_item_ff),
      .alpha (alpha_ff),
      .pad   (pad_ff),
      .res   (res)
   );

   // result buffer: load a fresh group or shift one word out
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_left_ff <= '0;
      end else if (advance) begin
         grp_left_ff <= res.n;
      end else if (rsp_fire) begin
         grp_left_ff <= grp_left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         grp_val_ff <= res.val;
      end else if (rsp_fire) begin
         grp_val_ff <= {8'h00, grp_val_ff[3], grp_val_ff[2], grp_val_ff[1]};
      end
   end

   assign rsp_chan.valid     = grp_left_ff != 3'd0;
   assign rsp_chan.out_value = grp_val_ff[0];
   assign rsp_chan.out_last  = grp_left_ff == 3'd1;

   // checks
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      grp_left_ff <= 3'd4)
      else $error("result buffer count out of range");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && grp_left_ff == 3'd0 |-> req_chan.ready)
      else $error("input held although result buffer empty");

   a_results_show: assert property (@(posedge clock) disable iff (reset)
      advance && res.n != 3'd0 |=> rsp_chan.valid && grp_left_ff == $past(res.n))
      else $error("results of a stepped item not presented");

endmodule

>>> sim/tb_base64_codec.sv
`timescale 1ns / 1ps
// Self-checking bench for base64_codec: random and directed encode/decode traffic,
// checked word by word against a built-in model of the codec across several alphabets.
// Depends on b64_pkg, the three channel interfaces and the codec RTL.
module tb_base64_codec;
   import b64_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int NO_INDEX = ALPHA_SIZE;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA0_IDX = 3'd0;

   localparam string STD_ALPHA =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam string URL_ALPHA =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } codec_word_type;

   logic clock = 1'b0;
   logic reset;

   b64_req_if req_if();
   b64_rsp_if rsp_if();
   b64_csr_if csr_if();

   base64_codec u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // words waiting to go in, and words the codec still owes
   item_type       req_items[$];
   codec_word_type due_words[$];
   int queued_items = 0;
   int taken_items = 0;
   int bad_words = 0;
   int idle_cycles = 0;
   int send_idle;
   int recv_idle;

   // alphabet and pad last written, used to build decode traffic
   logic [ALPHA_BITS-1:0] gen_alpha;
   logic [SYM_W-1:0]      gen_pad;

   // model state of the codec
   logic [ALPHA_BITS-1:0] cur_alpha;
   logic [SYM_W-1:0]      cur_pad;
   logic [17:0]           grp_bits;
   int                    grp_len;
   bit                    stopped;
   bit                    decoding;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [SYM_W-1:0] alpha_sym(logic [ALPHA_BITS-1:0] a, int idx);
      return a[idx * SYM_W +: SYM_W];
   endfunction

   // reverse lookup: the highest matching index wins, top-bit codes never match
   function automatic int alpha_index(logic [ALPHA_BITS-1:0] a, logic [7:0] code);
      int hit;
      hit = NO_INDEX;
      if (!code[7]) begin
         for (int i = 0; i < ALPHA_SIZE; i++)
            if (a[i * SYM_W +: SYM_W] == code[6:0]) hit = i;
      end
      return hit;
   endfunction

   function automatic logic [7:0] enc_sym(logic [5:0] idx);
      return {1'b0, alpha_sym(cur_alpha, idx)};
   endfunction

   function automatic logic [ALPHA_BITS-1:0] pack_alpha(string s);
      logic [ALPHA_BITS-1:0] bits;
      bits = '0;
      for (int i = 0; i < ALPHA_SIZE; i++) bits[i * SYM_W +: SYM_W] = 7'(s[i]);
      return bits;
   endfunction

   // advance the model by one accepted word and queue the words it owes
   function automatic void step_codec(logic [1:0] f, logic [7:0] v);
      logic [7:0]     vals[$];
      logic [23:0]    t;
      int             idx;
      codec_word_type w;
      case (f)
         FUNC_ENCODE: begin
            // a direction change drops the partial group
            if (decoding) begin
               grp_bits = '0;
               grp_len = 0;
               stopped = 1'b0;
               decoding = 1'b0;
            end
            if (grp_len < 2) begin
               grp_bits = {2'b00, grp_bits[7:0], v};
               grp_len++;
            end else begin
               t = {grp_bits[15:0], v};
               vals = '{enc_sym(t[23:18]), enc_sym(t[17:12]), enc_sym(t[11:6]),
                        enc_sym(t[5:0])};
               grp_bits = '0;
               grp_len = 0;
            end
         end
         FUNC_DECODE: begin
            if (!decoding) begin
               grp_bits = '0;
               grp_len = 0;
               stopped = 1'b0;
               decoding = 1'b1;
            end
            if (!stopped) begin
               idx = alpha_index(cur_alpha, v);
               if (idx == NO_INDEX) begin
                  // first symbol outside the alphabet: flush and stop
                  t = {grp_bits, 6'b0};
                  if (grp_len == 3) vals = '{t[23:16], t[15:8]};
                  else if (grp_len == 2) vals = '{grp_bits[11:4]};
                  grp_bits = '0;
                  grp_len = 0;
                  stopped = 1'b1;
               end else if (grp_len < 3) begin
                  grp_bits = {grp_bits[11:0], 6'(idx)};
                  grp_len++;
               end else begin
                  t = {grp_bits, 6'(idx)};
                  vals = '{t[23:16], t[15:8], t[7:0]};
                  grp_bits = '0;
                  grp_len = 0;
               end
            end
         end
         FUNC_FINISH: begin
            if (decoding) begin
               t = {grp_bits, 6'b0};
               if (grp_len == 3) vals = '{t[23:16], t[15:8]};
               else if (grp_len == 2) vals = '{grp_bits[11:4]};
            end else begin
               t = {grp_bits[15:0], 8'b0};
               if (grp_len == 1)
                  vals = '{enc_sym(t[15:10]), enc_sym({t[9:8], 4'b0}),
                           {1'b0, cur_pad}, {1'b0, cur_pad}};
               else if (grp_len == 2)
                  vals = '{enc_sym(t[23:18]), enc_sym(t[17:12]), enc_sym(t[11:6]),
                           {1'b0, cur_pad}};
            end
            grp_bits = '0;
            grp_len = 0;
            stopped = 1'b0;
         end
         default: ;
      endcase
      foreach (vals[k]) begin
         w.value = vals[k];
         w.last = (k == vals.size() - 1);
         due_words = {due_words, w};
      end
   endfunction

   // drive request words from the queue, idling at random
   always @(posedge clock) begin : drive_req
      item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_items.size() != 0 && $urandom_range(99) >= send_idle) begin
            nxt = req_items.pop_front();
            req_if.valid <= 1'b1;
            req_if.func <= nxt.func;
            req_if.in_value <= nxt.value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // stall the result channel at random
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_idle);
   end

   // track register writes and accepted words, check every result word
   always @(posedge clock) begin : watch_chan
      codec_word_type want;
      if (reset) begin
         cur_alpha = '0;
         cur_pad = SYM_W'(PAD_RESET);
         grp_bits = '0;
         grp_len = 0;
         stopped = 1'b0;
         decoding = 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_PAD_IDX) cur_pad = csr_if.wdata[SYM_W-1:0];
            else cur_alpha[csr_if.index * 64 +: 64] = csr_if.wdata;
         end
         if (req_if.valid && req_if.ready) begin
            step_codec(req_if.func, req_if.in_value);
            taken_items++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_words.size() == 0) begin
               bad_words++;
               if (bad_words <= MAX_REPORTS)
                  $display("unexpected word: value %02h last %0b",
                           rsp_if.out_value, rsp_if.out_last);
            end else begin
               want = due_words.pop_front();
               if (rsp_if.out_value !== want.value || rsp_if.out_last !== want.last) begin
                  bad_words++;
                  if (bad_words <= MAX_REPORTS)
                     $display("word mismatch: value exp %02h got %02h, last exp %0b got %0b",
                              want.value, rsp_if.out_value, want.last, rsp_if.out_last);
               end
            end
         end
      end
   end

   // end the run if nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(logic [1:0] f, logic [7:0] v);
      item_type it;
      it.func = f;
      it.value = v;
      queued_items++;
      req_items = {req_items, it};
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_alpha(logic [ALPHA_BITS-1:0] bits, logic [SYM_W-1:0] pad);
      for (int k = 0; k < ALPHA_WORDS; k++)
         csr_write(CSR_ALPHA0_IDX + 3'(k), bits[k * 64 +: 64]);
      csr_write(CSR_PAD_IDX, {57'b0, pad});
      gen_alpha = bits;
      gen_pad = pad;
   endtask

   // hold until every word is in and every result has come, then let the pipe settle
   task automatic drain();
      while (taken_items != queued_items || due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly valid alphabet symbols, some pad and some arbitrary codes
   function automatic logic [7:0] pick_symbol();
      int r;
      r = $urandom_range(99);
      if (r < 80) return {1'b0, alpha_sym(gen_alpha, $urandom_range(ALPHA_SIZE - 1))};
      if (r < 88) return {1'b0, gen_pad};
      return 8'($urandom);
   endfunction

   // random messages: byte runs, symbol runs, mostly closed by a finish
   task automatic add_traffic(int target);
      int counted;
      int len;
      int roll;
      counted = 0;
      while (counted < target) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            len = $urandom_range(7);
            repeat (len) add_item(FUNC_ENCODE, 8'($urandom));
            counted += len;
         end else if (roll < 90) begin
            len = $urandom_range(9, 1);
            repeat (len) add_item(FUNC_DECODE, pick_symbol());
            counted += len;
         end else begin
            add_item(FUNC_UNUSED, 8'($urandom));
         end
         if (roll < 90 && $urandom_range(99) < 85) begin
            add_item(FUNC_FINISH, 8'($urandom));
            counted++;
         end
      end
   endtask

   initial begin : run_test
      logic [ALPHA_BITS-1:0] bits;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_ENCODE;
      req_if.in_value = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.wdata = '0;
      send_idle = 18;
      recv_idle = 77;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: standard alphabet
      write_alpha(pack_alpha(STD_ALPHA), SYM_W'("="));
      add_item(FUNC_ENCODE, 8'h00);
      add_item(FUNC_ENCODE, 8'hff);
      add_item(FUNC_ENCODE, 8'h80);
      // one and two byte tails with pad
      add_item(FUNC_ENCODE, 8'hff);
      add_item(FUNC_FINISH, 8'h00);
      add_item(FUNC_ENCODE, 8'h01);
      add_item(FUNC_ENCODE, 8'hfe);
      add_item(FUNC_FINISH, 8'hff);
      // finish on an empty group, then an unused code
      add_item(FUNC_FINISH, 8'h00);
      add_item(FUNC_UNUSED, 8'ha5);
      // full decode group at the alphabet ends
      add_item(FUNC_DECODE, "/");
      add_item(FUNC_DECODE, "+");
      add_item(FUNC_DECODE, "9");
      add_item(FUNC_DECODE, "A");
      // pad stops a three-symbol group, later symbols are dropped
      add_item(FUNC_DECODE, "Q");
      add_item(FUNC_DECODE, "x");
      add_item(FUNC_DECODE, "z");
      add_item(FUNC_DECODE, "=");
      add_item(FUNC_DECODE, "A");
      add_item(FUNC_FINISH, 8'h00);
      // top-bit code stops a one-symbol group, then a switch to encoding
      add_item(FUNC_DECODE, "g");
      add_item(FUNC_DECODE, 8'd200);
      add_item(FUNC_ENCODE, 8'h55);
      add_item(FUNC_FINISH, 8'h00);
      drain();

      // url-safe alphabet, zero pad; pause the sender midway until all results are in
      write_alpha(pack_alpha(URL_ALPHA), '0);
      add_traffic(12);
      drain();
      add_traffic(12);
      drain();

      // narrow symbol range gives duplicates; pad taken from the alphabet itself
      send_idle = 77;
      recv_idle = 18;
      for (int i = 0; i < ALPHA_SIZE; i++) bits[i * SYM_W +: SYM_W] = 7'($urandom_range(111, 48));
      write_alpha(bits, alpha_sym(bits, $urandom_range(ALPHA_SIZE - 1)));
      add_traffic(22);
      drain();

      // fully random register contents, no idling from here on
      send_idle = 0;
      recv_idle = 0;
      for (int k = 0; k < ALPHA_WORDS; k++) bits[k * 64 +: 64] = {$urandom, $urandom};
      write_alpha(bits, 7'($urandom));
      add_traffic(18);
      drain();

      // extremes: all-zero and all-one alphabets
      write_alpha('0, '1);
      add_traffic(4);
      drain();
      write_alpha('1, '0);
      add_traffic(4);
      drain();

      if (bad_words == 0 && due_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
